>>> design/alpha_blend_pixel_merge_macros.svh
// Assertion macros for the alpha blend pixel merge block
`ifndef ALPHA_BLEND_PIXEL_MERGE_MACROS_SVH
`define ALPHA_BLEND_PIXEL_MERGE_MACROS_SVH
`ifndef SYNTHESIS
// clocked check on clk, off while rst_n is low
`define ABPM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// clocked check on clk that also holds during reset
`define ABPM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ABPM_ASSERT(lbl, prop, msg)
`define ABPM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> design/abpm_pkg.sv
// Package: payload types, register indexes and arithmetic helpers for the blend block
`timescale 1ns / 1ps
`default_nettype none
package abpm_pkg;

    localparam int SRC_W  = 8;
    localparam int COMP_W = 10;
    localparam int PROD_W = 18;
    localparam int IDX_W  = 3;
    localparam int DATA_W = 8;

    localparam logic [IDX_W-1:0] REG_GLOBAL_ALPHA = 3'd0;
    localparam logic [IDX_W-1:0] REG_CONVERT_MODE = 3'd1;
    localparam logic [IDX_W-1:0] REG_FIRST_DROP   = 3'd2;
    localparam logic [IDX_W-1:0] REG_SECOND_DROP  = 3'd3;
    localparam logic [IDX_W-1:0] REG_THIRD_DROP   = 3'd4;

    localparam logic [SRC_W-1:0] FULL_ALPHA = 8'd255;

    typedef enum logic [1:0] {
        CONV_NONE  = 2'd0,
        CONV_TO_9  = 2'd1,
        CONV_TO_10 = 2'd2,
        CONV_SHIFT = 2'd3
    } conv_mode_t;

    typedef struct packed {
        logic [7:0] src_first;
        logic [7:0] src_second;
        logic [7:0] src_third;
        logic [7:0] src_alpha;
        logic [9:0] dst_first;
        logic [9:0] dst_second;
        logic [9:0] dst_third;
        logic       chroma_site;
    } in_t;

    typedef struct packed {
        logic [9:0] out_first;
        logic [9:0] out_second;
        logic [9:0] out_third;
        logic       merged;
    } out_t;

    typedef struct packed {
        logic mul_en;
        logic sum_en;
    } lane_ctl_t;

    // ((v >> 8) + v + 1) >> 8 on the 16-bit alpha product
    function automatic logic [SRC_W-1:0] div255_alpha(input logic [15:0] v);
        logic [16:0] t;
        begin
            t = 17'(v >> 8) + 17'(v) + 17'd1;
            div255_alpha = t[15:8];
        end
    endfunction

    // p*511/255 = 2p + (p == 255); p*1023/255 = 4p + floor(3p/255)
    function automatic logic [COMP_W-1:0] convert_comp(
        input conv_mode_t       mode,
        input logic [SRC_W-1:0] p,
        input logic [2:0]       drop
    );
        logic [1:0] thirds;
        begin
            if (p == 8'd255) begin
                thirds = 2'd3;
            end else if (p >= 8'd170) begin
                thirds = 2'd2;
            end else if (p >= 8'd85) begin
                thirds = 2'd1;
            end else begin
                thirds = 2'd0;
            end
            case (mode)
                CONV_TO_9:  convert_comp = 10'({p, 1'b0}) + 10'(p == 8'd255);
                CONV_TO_10: convert_comp = {p, 2'b00} + 10'(thirds);
                CONV_SHIFT: convert_comp = 10'(p >> drop);
                default:    convert_comp = 10'(p);
            endcase
        end
    endfunction

endpackage
`default_nettype wire

>>> design/abpm_lane.sv
// One component blend lane: multiply stage, then sum and divide-by-255 stage
`timescale 1ns / 1ps
`default_nettype none
module abpm_lane (
    input  wire logic                          clk,
    input  wire abpm_pkg::lane_ctl_t           ctl,
    input  wire logic [abpm_pkg::SRC_W-1:0]    alpha,
    input  wire logic [abpm_pkg::COMP_W-1:0]   src,
    input  wire logic [abpm_pkg::COMP_W-1:0]   dst,
    input  wire logic                          pass,
    output logic      [abpm_pkg::COMP_W-1:0]   result
);

    logic [abpm_pkg::PROD_W-1:0] keep_prod_reg;
    logic [abpm_pkg::PROD_W-1:0] src_prod_reg;
    logic [abpm_pkg::COMP_W-1:0] dst_reg;
    logic                        pass_reg;
    logic [abpm_pkg::COMP_W-1:0] result_reg;
    logic [abpm_pkg::COMP_W-1:0] result_next;
    logic [abpm_pkg::SRC_W-1:0]  inv_alpha;
    logic [19:0]                 sum;
    logic [19:0]                 rounded;

    assign inv_alpha = abpm_pkg::FULL_ALPHA - alpha;

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            keep_prod_reg <= 18'(inv_alpha) * 18'(dst);
            src_prod_reg  <= 18'(alpha) * 18'(src);
            dst_reg       <= dst;
            pass_reg      <= pass;
        end
    end

    always_comb
    begin
        sum     = 20'(keep_prod_reg) + 20'(src_prod_reg);
        rounded = (sum >> 8) + sum + 20'd1;
        result_next = pass_reg ? dst_reg : rounded[17:8];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sum_en)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule
`default_nettype wire

>>> design/alpha_blend_pixel_merge.sv
// Throughput: one pixel per cycle while out_stall does not hold the pipeline; four
// register stages (alpha product, alpha divide, component multiply, sum and divide)
// advance under one stall chain.
// Reset empties the pipeline and returns the registers to their defaults
// (global_alpha 255, no conversion, zero drops).
`timescale 1ns / 1ps
`default_nettype none
`include "alpha_blend_pixel_merge_macros.svh"
module alpha_blend_pixel_merge (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire abpm_pkg::in_t                 in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output abpm_pkg::out_t                     out_data,
    input  wire logic                          cfg_we,
    input  wire logic [abpm_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [abpm_pkg::DATA_W-1:0]   cfg_data
);

    logic [7:0]           global_alpha_reg;
    abpm_pkg::conv_mode_t convert_mode_reg;
    logic [2:0]           first_drop_reg;
    logic [2:0]           second_drop_reg;
    logic [2:0]           third_drop_reg;

    logic en1, en2, en3, en4;
    logic v1_reg, v2_reg, v3_reg, out_valid_reg;

    logic [15:0]                  s1_prod_reg;
    logic [abpm_pkg::COMP_W-1:0]  s1_src_reg [3];
    logic [abpm_pkg::COMP_W-1:0]  s1_dst_reg [3];
    logic                         s1_chroma_reg;

    logic [abpm_pkg::SRC_W-1:0]   s2_alpha_reg;
    logic [abpm_pkg::COMP_W-1:0]  s2_src_reg [3];
    logic [abpm_pkg::COMP_W-1:0]  s2_dst_reg [3];
    logic                         s2_chroma_reg;

    logic s3_merged_reg;
    logic out_merged_reg;

    abpm_pkg::lane_ctl_t         lane_ctl;
    logic [abpm_pkg::COMP_W-1:0] lane_result [3];
    logic                        lane_pass   [3];

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            global_alpha_reg <= abpm_pkg::FULL_ALPHA;
            convert_mode_reg <= abpm_pkg::CONV_NONE;
            first_drop_reg   <= 3'd0;
            second_drop_reg  <= 3'd0;
            third_drop_reg   <= 3'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                abpm_pkg::REG_GLOBAL_ALPHA: global_alpha_reg <= cfg_data;
                abpm_pkg::REG_CONVERT_MODE:
                    convert_mode_reg <= abpm_pkg::conv_mode_t'(cfg_data[1:0]);
                abpm_pkg::REG_FIRST_DROP:   first_drop_reg  <= cfg_data[2:0];
                abpm_pkg::REG_SECOND_DROP:  second_drop_reg <= cfg_data[2:0];
                abpm_pkg::REG_THIRD_DROP:   third_drop_reg  <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // stall chain: a stage moves when it is empty or the next one moves
    assign en4 = !out_valid_reg || !out_stall;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) out_valid_reg <= v3_reg;
        end
    end

    // stage 1: alpha product and source conversion
    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            s1_prod_reg   <= 16'(global_alpha_reg) * 16'(in_data.src_alpha);
            s1_src_reg[0] <= abpm_pkg::convert_comp(convert_mode_reg, in_data.src_first,
                                                    first_drop_reg);
            s1_src_reg[1] <= abpm_pkg::convert_comp(convert_mode_reg, in_data.src_second,
                                                    second_drop_reg);
            s1_src_reg[2] <= abpm_pkg::convert_comp(convert_mode_reg, in_data.src_third,
                                                    third_drop_reg);
            s1_dst_reg[0] <= in_data.dst_first;
            s1_dst_reg[1] <= in_data.dst_second;
            s1_dst_reg[2] <= in_data.dst_third;
            s1_chroma_reg <= in_data.chroma_site;
        end
    end

    // stage 2: effective alpha
    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            s2_alpha_reg  <= abpm_pkg::div255_alpha(s1_prod_reg);
            s2_src_reg    <= s1_src_reg;
            s2_dst_reg    <= s1_dst_reg;
            s2_chroma_reg <= s1_chroma_reg;
        end
    end

    // stages 3 and 4: per-component lanes
    assign lane_ctl.mul_en = en3 && v2_reg;
    assign lane_ctl.sum_en = en4 && v3_reg;

    assign lane_pass[0] = (s2_alpha_reg == '0);
    assign lane_pass[1] = (s2_alpha_reg == '0) || !s2_chroma_reg;
    assign lane_pass[2] = (s2_alpha_reg == '0) || !s2_chroma_reg;

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        abpm_lane u_lane (
            .clk    (clk),
            .ctl    (lane_ctl),
            .alpha  (s2_alpha_reg),
            .src    (s2_src_reg[i]),
            .dst    (s2_dst_reg[i]),
            .pass   (lane_pass[i]),
            .result (lane_result[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (lane_ctl.mul_en)
        begin
            s3_merged_reg <= (s2_alpha_reg != '0);
        end
        if (lane_ctl.sum_en)
        begin
            out_merged_reg <= s3_merged_reg;
        end
    end

    assign out_valid           = out_valid_reg;
    assign out_data.out_first  = lane_result[0];
    assign out_data.out_second = lane_result[1];
    assign out_data.out_third  = lane_result[2];
    assign out_data.merged     = out_merged_reg;

    `ABPM_ASSERT_ALWAYS(a_stall_only_when_full, in_stall |-> v1_reg, "input stalled with stage 1 empty")
    `ABPM_ASSERT(a_out_loaded, (v3_reg && en4) |=> out_valid, "stage 3 item not delivered to output")
    `ABPM_ASSERT(a_full_pipe_stalls, (out_stall && out_valid && v3_reg && v2_reg && v1_reg) |-> in_stall, "full pipeline took a transfer while stalled")

endmodule
`default_nettype wire
